FILE: rtl/ccirc_pkg.sv
// Shared types and constants for the circumcircle pipeline.
`default_nettype none
package ccirc_pkg;

    // default coordinate width of one input field
    localparam int COORD_BITS_DEF = 12;

    // configuration register
    localparam int               CFG_W         = 16;
    localparam logic [CFG_W-1:0] MIN_DET_RESET = 16'd1;

    // result field widths
    localparam int CENTRE_W = 32;
    localparam int RSQ_W    = 56;

    // quotient bits produced by each divider; wide enough for the radius,
    // the centre checks its narrower range after the divide
    localparam int QUO_W = RSQ_W;

    // centre clipping limits (as magnitudes)
    localparam logic [QUO_W-1:0]    CENTRE_POS_MAX = QUO_W'(64'h0000_0000_7FFF_FFFF);
    localparam logic [QUO_W-1:0]    CENTRE_NEG_MAX = QUO_W'(64'h0000_0000_8000_0000);
    localparam logic [CENTRE_W-1:0] CENTRE_POS_SAT = 32'h7FFF_FFFF;
    localparam logic [CENTRE_W-1:0] CENTRE_NEG_SAT = 32'h8000_0000;

    // side information that travels with each beat through the dividers
    typedef struct packed {
        logic valid_res;
        logic x_neg;
        logic y_neg;
    } ccirc_tag_t;

endpackage
`default_nettype wire

FILE: rtl/circumcircle_from_three_points_top.sv
// Top level: circumcircle of three points, streaming pipeline.
//
//  channel  | dir | beat contents (lowest bits first)
//  ---------+-----+----------------------------------------------------------
//  s_       | in  | tdata: first_x, first_y, middle_x, middle_y, last_x, last_y
//  m_       | out | tdata: center_x, center_y, radius_sq; tuser: valid_res, saturated
//  cfg_     | in  | cfg_wdata: min_abs_det, written when cfg_wen is high
//
//  One beat per cycle while the output is not stalled; the path is the six front-end
//  stages, each divider's entry stage and 56 quotient-bit stages, and the output register.
//  Reset (aresetn low, synchronous) empties the pipeline and sets min_abs_det to 1.
//  The whole pipeline advances when the output register is empty or being taken;
//  s_tready follows that, so a stall holds every stage in place.
`default_nettype none
module circumcircle_from_three_points_top #(
    parameter int COORD_BITS = ccirc_pkg::COORD_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration
    input  wire logic                             cfg_wen,
    input  wire logic [ccirc_pkg::CFG_W-1:0]      cfg_wdata,
    // input beats
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // first_x, first_y, middle_x, middle_y, last_x, last_y, zero pad
    input  wire logic [((6*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // result beats
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // center_x, center_y, radius_sq
    output logic [2*ccirc_pkg::CENTRE_W+ccirc_pkg::RSQ_W-1:0] m_tdata,
    // valid_res, saturated
    output logic [1:0]                            m_tuser
);
    import ccirc_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int AW  = 2 * C + 4;
    localparam int DEW = 3 * C + 5;
    localparam int NCW = DEW + 9;
    localparam int DCW = AW + 1;
    localparam int NRW = 2 * DEW + 9;
    localparam int DRW = 2 * AW + 1;

    logic en;

    // configuration register
    logic [CFG_W-1:0] min_det_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_det_reg <= MIN_DET_RESET;
        end else if (cfg_wen) begin
            min_det_reg <= cfg_wdata;
        end
    end

    // front end
    logic           f_valid;
    ccirc_tag_t     f_tag;
    logic [NCW-1:0] f_cnx, f_cny;
    logic [DCW-1:0] f_cden;
    logic [NRW-1:0] f_rnum;
    logic [DRW-1:0] f_rden;

    ccirc_det #(
        .COORD_BITS (COORD_BITS)
    ) u_det (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_x0     (s_tdata[0*C +: C]),
        .in_y0     (s_tdata[1*C +: C]),
        .in_x1     (s_tdata[2*C +: C]),
        .in_y1     (s_tdata[3*C +: C]),
        .in_x2     (s_tdata[4*C +: C]),
        .in_y2     (s_tdata[5*C +: C]),
        .min_det   (min_det_reg),
        .out_valid (f_valid),
        .out_tag   (f_tag),
        .out_cnx   (f_cnx),
        .out_cny   (f_cny),
        .out_cden  (f_cden),
        .out_rnum  (f_rnum),
        .out_rden  (f_rden)
    );

    // three dividers in lock step; each carries the beat's tag
    logic             dv_valid, dvx_valid, dvy_valid, dvr_valid;
    ccirc_tag_t       dv_tag, tag_x, tag_y;
    logic [QUO_W-1:0] qx, qy, qr;
    logic             ovx, ovy, ovr;

    ccirc_div #(.NW(NCW), .DW(DCW), .QB(QUO_W)) u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .num       (f_cnx),
        .den       (f_cden),
        .in_tag    (f_tag),
        .out_valid (dvx_valid),
        .quo       (qx),
        .ovf       (ovx),
        .out_tag   (tag_x)
    );

    ccirc_div #(.NW(NCW), .DW(DCW), .QB(QUO_W)) u_div_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .num       (f_cny),
        .den       (f_cden),
        .in_tag    (f_tag),
        .out_valid (dvy_valid),
        .quo       (qy),
        .ovf       (ovy),
        .out_tag   (tag_y)
    );

    ccirc_div #(.NW(NRW), .DW(DRW), .QB(QUO_W)) u_div_r (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .num       (f_rnum),
        .den       (f_rden),
        .in_tag    (f_tag),
        .out_valid (dvr_valid),
        .quo       (qr),
        .ovf       (ovr),
        .out_tag   (dv_tag)
    );

    // the three valid chains are identical
    assign dv_valid = dvr_valid && dvx_valid && dvy_valid;

    // sign, clipping and the output register
    logic [CENTRE_W-1:0] cx_next, cy_next, cx_reg, cy_reg;
    logic [RSQ_W-1:0]    rsq_next, rsq_reg;
    logic                satx, saty, sat_next, sat_reg, vres_reg, ov_reg;

    always_comb begin
        if (tag_x.x_neg) begin
            satx    = ovx || (qx > CENTRE_NEG_MAX);
            cx_next = satx ? CENTRE_NEG_SAT : CENTRE_W'(-qx[CENTRE_W-1:0]);
        end else begin
            satx    = ovx || (qx > CENTRE_POS_MAX);
            cx_next = satx ? CENTRE_POS_SAT : qx[CENTRE_W-1:0];
        end
        if (tag_y.y_neg) begin
            saty    = ovy || (qy > CENTRE_NEG_MAX);
            cy_next = saty ? CENTRE_NEG_SAT : CENTRE_W'(-qy[CENTRE_W-1:0]);
        end else begin
            saty    = ovy || (qy > CENTRE_POS_MAX);
            cy_next = saty ? CENTRE_POS_SAT : qy[CENTRE_W-1:0];
        end
        rsq_next = ovr ? {RSQ_W{1'b1}} : qr[RSQ_W-1:0];
        sat_next = satx || saty || ovr;
        // singular points give all zeros
        if (!dv_tag.valid_res) begin
            cx_next  = '0;
            cy_next  = '0;
            rsq_next = '0;
            sat_next = 1'b0;
        end
    end

    assign en = !ov_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (en) begin
            ov_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            rsq_reg  <= rsq_next;
            sat_reg  <= sat_next;
            vres_reg <= dv_tag.valid_res;
        end
    end

    assign s_tready = en;
    assign m_tvalid = ov_reg;
    assign m_tdata  = {rsq_reg, cy_reg, cx_reg};
    assign m_tuser  = {sat_reg, vres_reg};

endmodule
`default_nettype wire

FILE: rtl/ccirc_det.sv
// Determinant front end: six pipeline stages from coordinates to divider operands.
`default_nettype none
module ccirc_det #(
    parameter int COORD_BITS = ccirc_pkg::COORD_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic [COORD_BITS-1:0]      in_x0,
    input  wire logic [COORD_BITS-1:0]      in_y0,
    input  wire logic [COORD_BITS-1:0]      in_x1,
    input  wire logic [COORD_BITS-1:0]      in_y1,
    input  wire logic [COORD_BITS-1:0]      in_x2,
    input  wire logic [COORD_BITS-1:0]      in_y2,
    input  wire logic [ccirc_pkg::CFG_W-1:0] min_det,
    output logic                            out_valid,
    output ccirc_pkg::ccirc_tag_t           out_tag,
    output logic [3*COORD_BITS+13:0]        out_cnx,
    output logic [3*COORD_BITS+13:0]        out_cny,
    output logic [2*COORD_BITS+4:0]         out_cden,
    output logic [6*COORD_BITS+18:0]        out_rnum,
    output logic [4*COORD_BITS+8:0]         out_rden
);
    import ccirc_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int DFW  = C + 1;            // coordinate differences, signed
    localparam int PW   = 2 * C + 2;        // x * dy products, signed
    localparam int AW   = 2 * C + 4;        // determinant a, signed
    localparam int RW   = 2 * C + 1;        // x^2 + y^2, unsigned
    localparam int P3W  = 3 * C + 3;        // r * dy products, signed
    localparam int DEW  = 3 * C + 5;        // d, e, dt, et, signed
    localparam int NCW  = DEW + 9;          // centre numerator
    localparam int DCW  = AW + 1;           // centre denominator
    localparam int H    = (DEW + 1) / 2;    // split point for dt^2, et^2
    localparam int SQW  = 2 * DEW;
    localparam int HA   = (AW + 1) / 2;     // split point for a^2
    localparam int ASW  = 2 * AW;
    localparam int NRW  = SQW + 9;          // radius numerator
    localparam int DRW  = ASW + 1;          // radius denominator
    localparam int MW   = (AW > CFG_W) ? AW : CFG_W;

    // ---------------- stage 1: input registers ----------------
    logic                s1_v_reg;
    logic [C-1:0]        x0_reg, y0_reg, x1_reg, y1_reg, x2_reg, y2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
        end else if (en) begin
            s1_v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg <= in_x0;
            y0_reg <= in_y0;
            x1_reg <= in_x1;
            y1_reg <= in_y1;
            x2_reg <= in_x2;
            y2_reg <= in_y2;
        end
    end

    // ---------------- stage 2: differences, squares, a products ----------------
    logic                  s2_v_reg;
    logic signed [DFW-1:0] dy12_next, dy20_next, dy01_next, dx12_next, dx20_next, dx01_next;
    logic signed [DFW-1:0] u1_next, v1_next, u2_next, v2_next;
    logic signed [PW-1:0]  pa0_next, pa1_next, pa2_next;
    logic [RW-1:0]         r0_next, r1_next, r2_next, s1_next, s2_next;
    logic signed [RW:0]    s1w, s2w;

    logic signed [DFW-1:0] dy12_reg, dy20_reg, dy01_reg, dx12_reg, dx20_reg, dx01_reg;
    logic signed [DFW-1:0] u1_reg, v1_reg, u2_reg, v2_reg;
    logic signed [PW-1:0]  pa0_reg, pa1_reg, pa2_reg;
    logic [RW-1:0]         r0_reg, r1_reg, r2_reg, s1_reg, s2_reg;

    always_comb begin
        dy12_next = $signed({1'b0, y1_reg}) - $signed({1'b0, y2_reg});
        dy20_next = $signed({1'b0, y2_reg}) - $signed({1'b0, y0_reg});
        dy01_next = $signed({1'b0, y0_reg}) - $signed({1'b0, y1_reg});
        dx12_next = $signed({1'b0, x1_reg}) - $signed({1'b0, x2_reg});
        dx20_next = $signed({1'b0, x2_reg}) - $signed({1'b0, x0_reg});
        dx01_next = $signed({1'b0, x0_reg}) - $signed({1'b0, x1_reg});
        u1_next   = $signed({1'b0, x1_reg}) - $signed({1'b0, x0_reg});
        v1_next   = $signed({1'b0, y1_reg}) - $signed({1'b0, y0_reg});
        u2_next   = $signed({1'b0, x2_reg}) - $signed({1'b0, x0_reg});
        v2_next   = $signed({1'b0, y2_reg}) - $signed({1'b0, y0_reg});
        pa0_next  = PW'($signed({1'b0, x0_reg}) * dy12_next);
        pa1_next  = PW'($signed({1'b0, x1_reg}) * dy20_next);
        pa2_next  = PW'($signed({1'b0, x2_reg}) * dy01_next);
        r0_next   = RW'(x0_reg) * RW'(x0_reg) + RW'(y0_reg) * RW'(y0_reg);
        r1_next   = RW'(x1_reg) * RW'(x1_reg) + RW'(y1_reg) * RW'(y1_reg);
        r2_next   = RW'(x2_reg) * RW'(x2_reg) + RW'(y2_reg) * RW'(y2_reg);
        s1w       = (RW+1)'(u1_next * u1_next) + (RW+1)'(v1_next * v1_next);
        s2w       = (RW+1)'(u2_next * u2_next) + (RW+1)'(v2_next * v2_next);
        s1_next   = s1w[RW-1:0];
        s2_next   = s2w[RW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_v_reg <= 1'b0;
        end else if (en) begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dy12_reg <= dy12_next;
            dy20_reg <= dy20_next;
            dy01_reg <= dy01_next;
            dx12_reg <= dx12_next;
            dx20_reg <= dx20_next;
            dx01_reg <= dx01_next;
            u1_reg   <= u1_next;
            v1_reg   <= v1_next;
            u2_reg   <= u2_next;
            v2_reg   <= v2_next;
            pa0_reg  <= pa0_next;
            pa1_reg  <= pa1_next;
            pa2_reg  <= pa2_next;
            r0_reg   <= r0_next;
            r1_reg   <= r1_next;
            r2_reg   <= r2_next;
            s1_reg   <= s1_next;
            s2_reg   <= s2_next;
        end
    end

    // ---------------- stage 3: sum a, products for d, e, dt, et ----------------
    logic                  s3_v_reg;
    logic signed [AW-1:0]  a_next, a_reg;
    logic signed [P3W-1:0] pd0_next, pd1_next, pd2_next, pe0_next, pe1_next, pe2_next;
    logic signed [P3W-1:0] pdt0_next, pdt1_next, pet0_next, pet1_next;
    logic signed [P3W-1:0] pd0_reg, pd1_reg, pd2_reg, pe0_reg, pe1_reg, pe2_reg;
    logic signed [P3W-1:0] pdt0_reg, pdt1_reg, pet0_reg, pet1_reg;

    always_comb begin
        a_next    = AW'(pa0_reg) + AW'(pa1_reg) + AW'(pa2_reg);
        pd0_next  = P3W'($signed({1'b0, r0_reg}) * dy12_reg);
        pd1_next  = P3W'($signed({1'b0, r1_reg}) * dy20_reg);
        pd2_next  = P3W'($signed({1'b0, r2_reg}) * dy01_reg);
        pe0_next  = P3W'($signed({1'b0, r0_reg}) * dx12_reg);
        pe1_next  = P3W'($signed({1'b0, r1_reg}) * dx20_reg);
        pe2_next  = P3W'($signed({1'b0, r2_reg}) * dx01_reg);
        pdt0_next = P3W'($signed({1'b0, s1_reg}) * v2_reg);
        pdt1_next = P3W'($signed({1'b0, s2_reg}) * v1_reg);
        pet0_next = P3W'($signed({1'b0, s1_reg}) * u2_reg);
        pet1_next = P3W'($signed({1'b0, s2_reg}) * u1_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_v_reg <= 1'b0;
        end else if (en) begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg    <= a_next;
            pd0_reg  <= pd0_next;
            pd1_reg  <= pd1_next;
            pd2_reg  <= pd2_next;
            pe0_reg  <= pe0_next;
            pe1_reg  <= pe1_next;
            pe2_reg  <= pe2_next;
            pdt0_reg <= pdt0_next;
            pdt1_reg <= pdt1_next;
            pet0_reg <= pet0_next;
            pet1_reg <= pet1_next;
        end
    end

    // ---------------- stage 4: d, e, dt, et, |a| and singular test ----------------
    logic                  s4_v_reg;
    logic signed [DEW-1:0] d_next, e_next, dt_next, et_next;
    logic signed [DEW-1:0] d_reg, e_reg, dt_reg, et_reg;
    logic [AW-1:0]         ua_next, ua_reg;
    logic                  aneg_next, aneg_reg, sing_next, sing_reg;

    always_comb begin
        d_next    = -(DEW'(pd0_reg) + DEW'(pd1_reg) + DEW'(pd2_reg));
        e_next    = DEW'(pe0_reg) + DEW'(pe1_reg) + DEW'(pe2_reg);
        dt_next   = DEW'(pdt1_reg) - DEW'(pdt0_reg);
        et_next   = DEW'(pet0_reg) - DEW'(pet1_reg);
        aneg_next = a_reg[AW-1];
        ua_next   = aneg_next ? AW'(-a_reg) : AW'(a_reg);
        sing_next = (ua_next == '0) || (MW'(ua_next) < MW'(min_det));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_v_reg <= 1'b0;
        end else if (en) begin
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg    <= d_next;
            e_reg    <= e_next;
            dt_reg   <= dt_next;
            et_reg   <= et_next;
            ua_reg   <= ua_next;
            aneg_reg <= aneg_next;
            sing_reg <= sing_next;
        end
    end

    // ---------------- stage 5: magnitudes, centre operands, square partials ----------------
    logic                 s5_v_reg;
    logic [DEW-1:0]       md, me, mdt, met;
    ccirc_tag_t           tag5_next, tag5_reg;
    logic [NCW-1:0]       cnx_next, cny_next, cnx5_reg, cny5_reg;
    logic [DCW-1:0]       cden_next, cden5_reg;
    logic [2*H-1:0]       dll_next, ell_next, dll_reg, ell_reg;
    logic [DEW-1:0]       dlh_next, elh_next, dlh_reg, elh_reg;
    logic [2*(DEW-H)-1:0] dhh_next, ehh_next, dhh_reg, ehh_reg;
    logic [2*HA-1:0]      all_next, all_reg;
    logic [AW-1:0]        alh_next, alh_reg;
    logic [2*(AW-HA)-1:0] ahh_next, ahh_reg;

    always_comb begin
        md  = d_reg[DEW-1]  ? DEW'(-d_reg)  : DEW'(d_reg);
        me  = e_reg[DEW-1]  ? DEW'(-e_reg)  : DEW'(e_reg);
        mdt = dt_reg[DEW-1] ? DEW'(-dt_reg) : DEW'(dt_reg);
        met = et_reg[DEW-1] ? DEW'(-et_reg) : DEW'(et_reg);
        tag5_next.valid_res = !sing_reg;
        tag5_next.x_neg     = (d_reg != '0) && (d_reg[DEW-1] == aneg_reg);
        tag5_next.y_neg     = (e_reg != '0) && (e_reg[DEW-1] == aneg_reg);
        // round to nearest: (256 |num| + |a|) / (2 |a|)
        cnx_next  = (NCW'(md) << 8) + NCW'(ua_reg);
        cny_next  = (NCW'(me) << 8) + NCW'(ua_reg);
        cden_next = {ua_reg, 1'b0};
        dll_next  = (2*H)'(mdt[H-1:0]) * (2*H)'(mdt[H-1:0]);
        dlh_next  = DEW'(mdt[H-1:0]) * DEW'(mdt[DEW-1:H]);
        dhh_next  = (2*(DEW-H))'(mdt[DEW-1:H]) * (2*(DEW-H))'(mdt[DEW-1:H]);
        ell_next  = (2*H)'(met[H-1:0]) * (2*H)'(met[H-1:0]);
        elh_next  = DEW'(met[H-1:0]) * DEW'(met[DEW-1:H]);
        ehh_next  = (2*(DEW-H))'(met[DEW-1:H]) * (2*(DEW-H))'(met[DEW-1:H]);
        all_next  = (2*HA)'(ua_reg[HA-1:0]) * (2*HA)'(ua_reg[HA-1:0]);
        alh_next  = AW'(ua_reg[HA-1:0]) * AW'(ua_reg[AW-1:HA]);
        ahh_next  = (2*(AW-HA))'(ua_reg[AW-1:HA]) * (2*(AW-HA))'(ua_reg[AW-1:HA]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_v_reg <= 1'b0;
        end else if (en) begin
            s5_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag5_reg  <= tag5_next;
            cnx5_reg  <= cnx_next;
            cny5_reg  <= cny_next;
            cden5_reg <= cden_next;
            dll_reg   <= dll_next;
            dlh_reg   <= dlh_next;
            dhh_reg   <= dhh_next;
            ell_reg   <= ell_next;
            elh_reg   <= elh_next;
            ehh_reg   <= ehh_next;
            all_reg   <= all_next;
            alh_reg   <= alh_next;
            ahh_reg   <= ahh_next;
        end
    end

    // ---------------- stage 6: squares and radius operands ----------------
    logic             s6_v_reg;
    logic [SQW-1:0]   dt2, et2;
    logic [ASW-1:0]   a2;
    logic [NRW-1:0]   rnum_next;
    logic [DRW-1:0]   rden_next;
    ccirc_tag_t       tag6_reg;
    logic [NCW-1:0]   cnx6_reg, cny6_reg;
    logic [DCW-1:0]   cden6_reg;
    logic [NRW-1:0]   rnum_reg;
    logic [DRW-1:0]   rden_reg;

    always_comb begin
        dt2 = (SQW'(dhh_reg) << (2*H)) + (SQW'(dlh_reg) << (H+1)) + SQW'(dll_reg);
        et2 = (SQW'(ehh_reg) << (2*H)) + (SQW'(elh_reg) << (H+1)) + SQW'(ell_reg);
        a2  = (ASW'(ahh_reg) << (2*HA)) + (ASW'(alh_reg) << (HA+1)) + ASW'(all_reg);
        // 256 rsq = 64 (dt^2 + et^2) / a^2, rounded: (128 S + A) / (2 A)
        rnum_next = ((NRW'(dt2) + NRW'(et2)) << 7) + NRW'(a2);
        rden_next = {a2, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_v_reg <= 1'b0;
        end else if (en) begin
            s6_v_reg <= s5_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag6_reg  <= tag5_reg;
            cnx6_reg  <= cnx5_reg;
            cny6_reg  <= cny5_reg;
            cden6_reg <= cden5_reg;
            rnum_reg  <= rnum_next;
            rden_reg  <= rden_next;
        end
    end

    assign out_valid = s6_v_reg;
    assign out_tag   = tag6_reg;
    assign out_cnx   = cnx6_reg;
    assign out_cny   = cny6_reg;
    assign out_cden  = cden6_reg;
    assign out_rnum  = rnum_reg;
    assign out_rden  = rden_reg;

endmodule
`default_nettype wire

FILE: rtl/ccirc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
`default_nettype none
module ccirc_div #(
    parameter int NW = 64,
    parameter int DW = 32,
    parameter int QB = ccirc_pkg::QUO_W
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [NW-1:0]         num,
    input  wire logic [DW-1:0]         den,
    input  wire ccirc_pkg::ccirc_tag_t in_tag,
    output logic                       out_valid,
    output logic [QB-1:0]              quo,
    output logic                       ovf,
    output ccirc_pkg::ccirc_tag_t      out_tag
);
    import ccirc_pkg::*;

    localparam int NE = QB + DW + 1;

    // per stage: partial remainder, remaining numerator bits shifted up with
    // quotient bits filling in from below
    logic [DW-1:0]  rem_reg  [0:QB];
    logic [QB-1:0]  wq_reg   [0:QB];
    logic [DW-1:0]  den_reg  [0:QB];
    logic           v_reg    [0:QB];
    logic           ovf_reg  [0:QB];
    ccirc_tag_t     tag_reg  [0:QB];

    logic [DW-1:0]  rem_next [0:QB];
    logic [QB-1:0]  wq_next  [0:QB];

    logic [NE-1:0]  num_ext;
    logic [DW:0]    hi;
    logic           ovf_next;

    // entry: quotient of QB bits fits only if num >> QB is below den;
    // then one shift, compare and subtract per stage
    always_comb begin
        num_ext     = NE'(num);
        hi          = num_ext[NE-1:QB];
        ovf_next    = hi >= {1'b0, den};
        rem_next[0] = ovf_next ? '0 : hi[DW-1:0];
        wq_next[0]  = num_ext[QB-1:0];
        for (int k = 1; k <= QB; k++) begin
            logic [DW:0] t;
            logic        ge;
            t  = {rem_reg[k-1], wq_reg[k-1][QB-1]};
            ge = t >= {1'b0, den_reg[k-1]};
            rem_next[k] = ge ? DW'(t - {1'b0, den_reg[k-1]}) : t[DW-1:0];
            wq_next[k]  = {wq_reg[k-1][QB-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= QB; k++) v_reg[k] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= QB; k++) v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= rem_next[0];
            wq_reg[0]  <= wq_next[0];
            den_reg[0] <= den;
            ovf_reg[0] <= ovf_next;
            tag_reg[0] <= in_tag;
            for (int k = 1; k <= QB; k++) begin
                rem_reg[k] <= rem_next[k];
                wq_reg[k]  <= wq_next[k];
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[QB];
    assign quo       = wq_reg[QB];
    assign ovf       = ovf_reg[QB];
    assign out_tag   = tag_reg[QB];

endmodule
`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the circumcircle-of-three-points pipeline.
`timescale 1ns / 1ps
module tb;
    import ccirc_pkg::*;

    localparam int CB       = 12;
    localparam int DATA_W   = ((6*CB+7)/8)*8;
    localparam int WDOG_MAX = 5000;

    typedef struct {
        bit [CB-1:0] fx, fy, mx, my, lx, ly;
    } tri_t;

    typedef struct {
        bit                valid_res;
        bit [CENTRE_W-1:0] cx;
        bit [CENTRE_W-1:0] cy;
        bit [RSQ_W-1:0]    rsq;
        bit                sat;
    } circle_t;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              cfg_wen = 1'b0;
    logic [CFG_W-1:0]                  cfg_wdata = '0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [DATA_W-1:0]                 s_tdata = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b1;
    logic [2*CENTRE_W+RSQ_W-1:0]       m_tdata;
    logic [1:0]                        m_tuser;

    circle_t     circle_q[$];
    bit [15:0]   min_det = 16'd1;
    bit          gaps_on = 1'b0;
    int unsigned n_sent = 0, n_got = 0, n_valid = 0, n_sat = 0;
    int unsigned n_err = 0;
    int unsigned stall_left = 0;
    int unsigned wdog = 0;

    circumcircle_from_three_points_top #(.COORD_BITS(CB)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic longint unsigned magn(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    // 256 * (-num / 2den), ties away from zero, clipped to 32 bit signed
    function automatic bit [31:0] centre_q8(longint num, longint den, inout bit sat);
        longint unsigned n, m, q;
        bit neg;
        n   = magn(num) << 7;
        m   = magn(den);
        q   = (2*n + m) / (2*m);
        neg = (num != 0) && ((num < 0) == (den < 0));
        if (neg) begin
            if (q > 64'h8000_0000) begin
                q   = 64'h8000_0000;
                sat = 1'b1;
            end
            return 32'(-q);
        end
        if (q > 64'h7FFF_FFFF) begin
            q   = 64'h7FFF_FFFF;
            sat = 1'b1;
        end
        return 32'(q);
    endfunction

    function automatic circle_t circumcircle(tri_t t);
        longint x0, y0, x1, y1, x2, y2, r0, r1, r2, a, d, e;
        longint u1, v1, u2, v2, s1, s2, dt, et;
        logic [127:0] mdt, met, ua, num, den, q;
        circle_t c;
        bit sat;
        x0 = t.fx; y0 = t.fy; x1 = t.mx; y1 = t.my; x2 = t.lx; y2 = t.ly;
        c   = '{default: '0};
        sat = 1'b0;
        a = x0*(y1-y2) + x1*(y2-y0) + x2*(y0-y1);
        if (a == 0 || magn(a) < min_det) return c;
        r0 = x0*x0 + y0*y0;
        r1 = x1*x1 + y1*y1;
        r2 = x2*x2 + y2*y2;
        d = -(r0*(y1-y2) + r1*(y2-y0) + r2*(y0-y1));
        e = r0*(x1-x2) + r1*(x2-x0) + r2*(x0-x1);
        c.valid_res = 1'b1;
        c.cx = centre_q8(d, a, sat);
        c.cy = centre_q8(e, a, sat);
        // radius in the frame moved to the first point, ties upward
        u1 = x1-x0; v1 = y1-y0; u2 = x2-x0; v2 = y2-y0;
        s1 = u1*u1 + v1*v1;
        s2 = u2*u2 + v2*v2;
        dt = -(s1*v2 - s2*v1);
        et = s1*u2 - s2*u1;
        mdt = magn(dt); met = magn(et); ua = magn(a);
        num = (mdt*mdt + met*met) << 6;
        den = ua*ua;
        q   = (2*num + den) / (2*den);
        if (q > {72'd0, {RSQ_W{1'b1}}}) begin
            c.rsq = '1;
            sat   = 1'b1;
        end else begin
            c.rsq = q[RSQ_W-1:0];
        end
        c.sat = sat;
        return c;
    endfunction

    // result side: random back-pressure bursts and checking
    always @(posedge aclk) begin
        circle_t exp_c;
        if (aresetn && m_tvalid && m_tready) begin
            n_got++;
            if (circle_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result beat %h", m_tdata);
            end else begin
                exp_c = circle_q.pop_front();
                if (exp_c.valid_res) n_valid++;
                if (exp_c.sat) n_sat++;
                if (m_tuser[0] !== exp_c.valid_res || m_tuser[1] !== exp_c.sat ||
                    m_tdata[31:0] !== exp_c.cx || m_tdata[63:32] !== exp_c.cy ||
                    m_tdata[119:64] !== exp_c.rsq) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch beat %0d: exp v=%b s=%b cx=%h cy=%h r=%h, got v=%b s=%b cx=%h cy=%h r=%h",
                                 n_got, exp_c.valid_res, exp_c.sat, exp_c.cx, exp_c.cy,
                                 exp_c.rsq, m_tuser[0], m_tuser[1], m_tdata[31:0],
                                 m_tdata[63:32], m_tdata[119:64]);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no beat moving either way
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) wdog = 0;
            else wdog++;
            if (wdog >= WDOG_MAX) begin
                $display("timeout: %0d results outstanding", circle_q.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_tri(tri_t t);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {t.ly, t.lx, t.my, t.mx, t.fy, t.fx};
        do @(posedge aclk); while (!s_tready);
        circle_q.push_back(circumcircle(t));
        n_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (circle_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_min_det(bit [15:0] v);
        drain();
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        min_det    = v;
    endtask

    function automatic bit [CB-1:0] clampc(int v);
        return v < 0 ? {CB{1'b0}} : (v > 4095 ? 12'hFFF : 12'(v));
    endfunction

    function automatic tri_t mk(int a, int b, int c, int d, int e, int f);
        tri_t t;
        t.fx = clampc(a); t.fy = clampc(b); t.mx = clampc(c);
        t.my = clampc(d); t.lx = clampc(e); t.ly = clampc(f);
        return t;
    endfunction

    // corners, degenerate cases, tiny determinants that clip
    task automatic test_directed();
        send_tri(mk(0, 0, 0, 0, 0, 0));
        send_tri(mk(4095, 4095, 4095, 4095, 4095, 4095));
        send_tri(mk(0, 0, 1, 1, 4095, 4095));
        send_tri(mk(5, 5, 5, 5, 9, 9));
        send_tri(mk(0, 0, 4095, 0, 0, 4095));
        send_tri(mk(4095, 4095, 0, 4095, 4095, 0));
        send_tri(mk(0, 4095, 4095, 0, 0, 0));
        send_tri(mk(0, 0, 1, 0, 0, 1));
        send_tri(mk(0, 0, 2, 1, 4095, 2047));
        send_tri(mk(0, 0, 4095, 1, 4094, 1));
        send_tri(mk(4095, 0, 0, 4094, 1, 4093));
        send_tri(mk(10, 20, 20, 10, 30, 20));
        send_tri(mk(0, 0, 2048, 1, 4095, 1));
        send_tri(mk(1, 2, 3, 4, 7, 5));
    endtask

    // determinant around the top threshold
    task automatic test_threshold();
        set_min_det(16'hFFFF);
        send_tri(mk(0, 0, 256, 0, 0, 256));
        send_tri(mk(0, 0, 255, 0, 0, 257));
        send_tri(mk(0, 0, 255, 0, 0, 256));
        send_tri(mk(0, 0, 4095, 0, 0, 4095));
        send_tri(mk(0, 0, 1, 0, 0, 1));
    endtask

    task automatic test_uniform(int n);
        repeat (n)
            send_tri(mk($urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom_range(0, 4095)));
    endtask

    // points close together: small determinants near the threshold
    task automatic test_cluster(int n);
        int bx, by, w;
        repeat (n) begin
            w  = $urandom_range(1, 40);
            bx = $urandom_range(0, 4095);
            by = $urandom_range(0, 4095);
            send_tri(mk(bx, by, bx + $urandom_range(0, w), by + $urandom_range(0, w),
                        bx - $urandom_range(0, w), by + $urandom_range(0, w)));
        end
    endtask

    // nearly collinear points: far centres, clipping and singular cases
    task automatic test_near_line(int n);
        int x0, y0, dx, dy, k, jx, jy;
        repeat (n) begin
            x0 = $urandom_range(0, 4095);
            y0 = $urandom_range(0, 4095);
            dx = int'($urandom_range(0, 600)) - 300;
            dy = int'($urandom_range(0, 600)) - 300;
            k  = $urandom_range(2, 13);
            jx = $urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(0, 6)) - 3;
            jy = int'($urandom_range(0, 2)) - 1;
            send_tri(mk(x0, y0, x0 + dx, y0 + dy, x0 + k*dx + jx, y0 + k*dy + jy));
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_threshold();
        set_min_det(16'd1);
        gaps_on = 1'b1;
        test_uniform(450);
        set_min_det(16'd16);
        test_cluster(350);
        set_min_det(16'hFFFF);
        test_near_line(200);
        set_min_det(16'($urandom_range(1, 65535)));
        test_near_line(150);
        test_cluster(100);
        set_min_det(16'd1);
        test_near_line(100);
        gaps_on = 1'b0;
        test_uniform(200);
        drain();
        repeat (70) @(posedge aclk);

        $display("sent %0d triangles, %0d results (%0d circles, %0d clipped)",
                 n_sent, n_got, n_valid, n_sat);
        $display("thresholds 1, 16, 65535 and random; uniform, clustered, near-line points");
        if (n_err == 0 && circle_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
